>>> rtl/fvpc_pkg.sv
// Shared types and constants of the fiducial volume polygon check.
// Holds the detector polygon vertex tables in whole centimeters; no dependencies.
`default_nettype none

package fvpc_pkg;

    localparam int POS_W        = 16;
    localparam int CUT_W        = 11;
    localparam int VERTEX_COUNT = 6;

    localparam logic [CUT_W-1:0] CUT_RESET = CUT_W'(48);

    typedef logic [CUT_W-1:0] t_cut;

    // Vertex base positions in cm, and whether the cut moves the coordinate down.
    localparam int XY_X_CM  [VERTEX_COUNT] = '{0, 80, 256, 256, 100, 0};
    localparam bit XY_X_NEG [VERTEX_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam int XY_Y_CM  [VERTEX_COUNT] = '{-116, -116, -99, 102, 116, 117};
    localparam bit XY_Y_NEG [VERTEX_COUNT] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam int XZ_X_CM  [VERTEX_COUNT] = '{0, 120, 256, 256, 120, 0};
    localparam bit XZ_X_NEG [VERTEX_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam int XZ_Z_CM  [VERTEX_COUNT] = '{0, 0, 11, 1026, 1037, 1037};
    localparam bit XZ_Z_NEG [VERTEX_COUNT] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

endpackage

`default_nettype wire

>>> rtl/fiducial_volume_polygon_check.sv
// Fiducial volume check: point inside both the x-y and x-z six-vertex polygons.
// Input, edge and result registers lead to the o_done strobe; throughput 1 point
// per cycle, set by the twelve three-stage edge pipelines; busy is always low and
// the receiver cannot stall. Synchronous active-low reset restores r_cut
// to 48 (3 cm) and clears the valid pipe. Depends on fvpc_pkg, fvpc_edge_test.
`default_nettype none

module fiducial_volume_polygon_check
    import fvpc_pkg::*;
#(
    parameter int FRAC_BITS = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic signed [POS_W-1:0] i_pos_z,
    input  wire                      i_cfg_we,
    input  wire logic [CUT_W-1:0]    i_cfg_wdata,
    output logic                     o_done,
    output logic                     o_inside_res
);

    // Vertex width: the largest base (1037 cm) plus the cut and the 1 cm offset.
    localparam int VW = FRAC_BITS + 13;

    t_cut r_cut;

    logic signed [VW-1:0] xy_x [VERTEX_COUNT];
    logic signed [VW-1:0] xy_y [VERTEX_COUNT];
    logic signed [VW-1:0] xz_x [VERTEX_COUNT];
    logic signed [VW-1:0] xz_z [VERTEX_COUNT];

    logic                    r_vld [4];
    logic signed [POS_W-1:0] r_x, r_y, r_z;

    logic [VERTEX_COUNT-1:0] xy_tog, xz_tog;

    logic r_done, r_inside;

    // The pipeline never holds off a point.
    assign busy = 1'b0;

    // Configuration: user must ensure it is written only while idle (unenforced), so vertices are static in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut <= CUT_RESET;
        end else if (i_cfg_we) begin
            r_cut <= i_cfg_wdata;
        end
    end

    // Build the vertices: scale the base to fixed point, move inward by the cut.
    // The x-z z coordinates move a further 1 cm inward.
    always_comb begin
        int c;
        int one;
        int cz;
        c   = int'(r_cut);
        one = 1 << FRAC_BITS;
        cz  = c + one;
        for (int k = 0; k < VERTEX_COUNT; k++) begin
            xy_x[k] = VW'(XY_X_CM[k] * one + (XY_X_NEG[k] ? -c : c));
            xy_y[k] = VW'(XY_Y_CM[k] * one + (XY_Y_NEG[k] ? -c : c));
            xz_x[k] = VW'(XZ_X_CM[k] * one + (XZ_X_NEG[k] ? -c : c));
            xz_z[k] = VW'(XZ_Z_CM[k] * one + (XZ_Z_NEG[k] ? -cz : cz));
        end
    end

    // Input stage: capture the point unconditionally; start does not gate it.
    always_ff @(posedge i_clk) begin
        r_x <= i_pos_x;
        r_y <= i_pos_y;
        r_z <= i_pos_z;
    end

    // Valid bits follow the point through the input stage and the edge stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k < 4; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Edge i runs from vertex j = i - 1 (wrapping) to vertex i.
    for (genvar g = 0; g < VERTEX_COUNT; g++) begin : g_edge
        localparam int J = (g + VERTEX_COUNT - 1) % VERTEX_COUNT;

        fvpc_edge_test #(.VW(VW)) u_xy (
            .i_clk    (i_clk),
            .i_vxi    (xy_x[g]),
            .i_vyi    (xy_y[g]),
            .i_vxj    (xy_x[J]),
            .i_vyj    (xy_y[J]),
            .i_tx     (r_x),
            .i_ty     (r_y),
            .o_toggle (xy_tog[g])
        );

        fvpc_edge_test #(.VW(VW)) u_xz (
            .i_clk    (i_clk),
            .i_vxi    (xz_x[g]),
            .i_vyi    (xz_z[g]),
            .i_vxj    (xz_x[J]),
            .i_vyj    (xz_z[J]),
            .i_tx     (r_x),
            .i_ty     (r_z),
            .o_toggle (xz_tog[g])
        );
    end

    // Even-odd rule: parity of the crossings per polygon, then intersect.
    always_ff @(posedge i_clk) begin
        r_inside <= (^xy_tog) & (^xz_tog);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[3];
        end
    end

    assign o_done       = r_done;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire

>>> rtl/fvpc_edge_test.sv
// One polygon edge of the even-odd crossing test, three register stages deep.
// Depends on fvpc_pkg for the point width.
`default_nettype none

module fvpc_edge_test
    import fvpc_pkg::*;
#(
    parameter int VW = 17
) (
    input  wire                     i_clk,
    input  wire logic signed [VW-1:0]    i_vxi,
    input  wire logic signed [VW-1:0]    i_vyi,
    input  wire logic signed [VW-1:0]    i_vxj,
    input  wire logic signed [VW-1:0]    i_vyj,
    input  wire logic signed [POS_W-1:0] i_tx,
    input  wire logic signed [POS_W-1:0] i_ty,
    output logic                    o_toggle
);

    localparam int DW = ((VW > POS_W) ? VW : POS_W) + 1;
    localparam int PW = 2 * DW;

    logic signed [DW-1:0] vxi, vyi, vxj, vyj, tx, ty;

    logic                 r_cross1, n_cross1;
    logic signed [DW-1:0] r_d, r_dx, r_ex, r_dy;
    logic                 r_cross2, r_dpos;
    logic signed [PW-1:0] r_lhs, r_rhs;
    logic                 r_toggle;

    assign vxi = DW'(i_vxi);
    assign vyi = DW'(i_vyi);
    assign vxj = DW'(i_vxj);
    assign vyj = DW'(i_vyj);
    assign tx  = DW'(i_tx);
    assign ty  = DW'(i_ty);

    // Crossed when exactly one end lies strictly above the test height.
    assign n_cross1 = (vyi > ty) != (vyj > ty);

    always_ff @(posedge i_clk) begin
        r_cross1 <= n_cross1;
        r_d      <= vyj - vyi;
        r_dx     <= tx - vxi;
        r_ex     <= vxj - vxi;
        r_dy     <= ty - vyi;
    end

    always_ff @(posedge i_clk) begin
        r_cross2 <= r_cross1;
        r_dpos   <= (r_d > 0);
        r_lhs    <= PW'(r_dx) * PW'(r_d);
        r_rhs    <= PW'(r_ex) * PW'(r_dy);
    end

    // Flip the comparison when vyj is not above vyi, in place of a divide.
    always_ff @(posedge i_clk) begin
        r_toggle <= r_cross2 && (r_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs));
    end

    assign o_toggle = r_toggle;

endmodule

`default_nettype wire
